>>> design/dt_pkg.sv
// shared types and constants of the delimiter tokenizer
`timescale 1ns / 1ps
`default_nettype none

package dt_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] token_char;
    logic       token_end;
    logic       run_last;
  } out_beat_t;

  // results owed for one input beat, in emission order:
  // held char, then a lead char, then the word "newline"
  typedef struct packed {
    logic       held_ok;
    logic [7:0] held_char;
    logic       held_end;
    logic       lead_ok;
    logic [7:0] lead_char;
    logic       word_ok;
  } dt_plan_t;

  localparam int unsigned WordLen = 7;

  function automatic logic [7:0] word_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h6e;  // n
      3'd1: c = 8'h65;  // e
      3'd2: c = 8'h77;  // w
      3'd3: c = 8'h6c;  // l
      3'd4: c = 8'h69;  // i
      3'd5: c = 8'h6e;  // n
      3'd6: c = 8'h65;  // e
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/delimiter_tokenizer.sv
// delimiter tokenizer top level: input register, classifier, result sequencer
// path: a beat's results pass the input register, the sequencer's plan register and the output register
// throughput: one input beat per cycle while the output is not stalled and each beat
//   yields at most one result; more results hold the sequencer (a newline yields up to 9)
// reset: asynchronous active low, clears the held character and all valid flags
`timescale 1ns / 1ps
`default_nettype none

module delimiter_tokenizer
  import dt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_beat_t  in_beat_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_beat_t      out_beat_o
);

  // input register: takes a beat whenever it is empty or draining
  logic     in_valid_q;
  in_beat_t in_q;
  logic     plan_take;
  logic     in_take;
  dt_plan_t plan;

  assign in_take    = in_valid_i && !in_stall_o;
  assign in_stall_o = in_valid_q && !plan_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (plan_take) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_beat_i;
    end
  end

  // classify the registered beat against the held char
  dt_plan u_plan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (in_q),
    .take_i (plan_take),
    .plan_o (plan)
  );

  // walk the plan one result per cycle into the output register while the output is not stalled
  dt_burst u_burst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .plan_valid_i (in_valid_q),
    .plan_i       (plan),
    .plan_take_o  (plan_take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_beat_o   (out_beat_o)
  );

endmodule

`default_nettype wire

>>> design/dt_plan.sv
// byte classifier and held-character state
`timescale 1ns / 1ps
`default_nettype none

module dt_plan
  import dt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_beat_t item_i,
  input  wire logic     take_i,
  output dt_plan_t      plan_o
);

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChVt    = 8'h0b;
  localparam logic [7:0] ChFf    = 8'h0c;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChLpar  = 8'h28;
  localparam logic [7:0] ChRpar  = 8'h29;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChSemi  = 8'h3b;
  localparam logic [7:0] ChBslash = 8'h5c;

  logic [7:0] held_char_q, held_char_d;
  logic       held_valid_q, held_valid_d;
  logic [7:0] c;

  assign c = item_i.text_byte;

  always_comb begin
    plan_o.held_ok   = 1'b0;
    plan_o.held_char = held_char_q;
    plan_o.held_end  = 1'b1;
    plan_o.lead_ok   = 1'b0;
    plan_o.lead_char = c;
    plan_o.word_ok   = 1'b0;
    held_char_d      = held_char_q;
    held_valid_d     = held_valid_q;
    if (item_i.end_of_text) begin
      plan_o.held_ok = held_valid_q;
      held_char_d    = '0;
      held_valid_d   = 1'b0;
    end else begin
      unique case (c) inside
        ChNul: begin
        end
        ChLf: begin
          plan_o.held_ok   = held_valid_q;
          plan_o.lead_ok   = 1'b1;
          plan_o.lead_char = ChBslash;
          plan_o.word_ok   = 1'b1;
          held_char_d      = '0;
          held_valid_d     = 1'b0;
        end
        ChTab, ChVt, ChFf, ChCr, ChSpace: begin
          plan_o.held_ok = held_valid_q;
          held_char_d    = '0;
          held_valid_d   = 1'b0;
        end
        ChLpar, ChRpar, ChBslash, ChSemi, ChQuote, ChComma: begin
          plan_o.held_ok = held_valid_q;
          plan_o.lead_ok = 1'b1;
          held_char_d    = '0;
          held_valid_d   = 1'b0;
        end
        default: begin
          // ordinary char: the held one continues the token
          plan_o.held_ok  = held_valid_q;
          plan_o.held_end = 1'b0;
          held_char_d     = c;
          held_valid_d    = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_char_q  <= '0;
      held_valid_q <= 1'b0;
    end else if (take_i) begin
      held_char_q  <= held_char_d;
      held_valid_q <= held_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> design/dt_burst.sv
// result sequencer and output register
`timescale 1ns / 1ps
`default_nettype none

module dt_burst
  import dt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      plan_valid_i,
  input  wire dt_plan_t  plan_i,
  output logic           plan_take_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_beat_t      out_beat_o
);

  localparam logic [3:0] StepHeld     = 4'd0;
  localparam logic [3:0] StepLead     = 4'd1;
  localparam logic [3:0] StepWordHead = 4'd2;
  localparam logic [3:0] StepWordTail = 4'(StepWordHead + WordLen - 1);

  dt_plan_t   plan_q;
  logic       busy_q;
  logic [3:0] step_q;
  logic       out_valid_q;
  out_beat_t  out_q;

  logic       load, emit, has_next;
  logic [2:0] word_idx;
  out_beat_t  slot;

  assign load     = !out_valid_q || !out_stall_i;
  assign emit     = busy_q && load;
  assign word_idx = 3'(step_q - StepWordHead);

  always_comb begin
    case (step_q)
      StepHeld: begin
        slot.token_char = plan_q.held_char;
        slot.token_end  = plan_q.held_end;
        has_next        = plan_q.lead_ok;
      end
      StepLead: begin
        slot.token_char = plan_q.lead_char;
        slot.token_end  = 1'b1;
        has_next        = plan_q.word_ok;
      end
      default: begin
        slot.token_char = word_char(word_idx);
        slot.token_end  = (step_q == StepWordTail);
        has_next        = (step_q != StepWordTail);
      end
    endcase
    slot.run_last = !has_next;
  end

  assign plan_take_o = plan_valid_i && (!busy_q || (emit && !has_next));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= StepHeld;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (load) begin
        out_valid_q <= 1'b0;
      end
      if (plan_take_o) begin
        busy_q <= plan_i.held_ok || plan_i.lead_ok;
        step_q <= plan_i.held_ok ? StepHeld : StepLead;
      end else if (emit) begin
        if (has_next) begin
          step_q <= step_q + 4'd1;
        end else begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (plan_take_o) begin
      plan_q <= plan_i;
    end
    if (emit) begin
      out_q <= slot;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

`default_nettype wire
